@@ rtl/slp_pkg.sv @@
// Package for the scrolling overlay lane placer: field widths, register
// indexes, reset values, the table entry type and controller/datapath bundles.
// No dependencies.
`timescale 1ns / 1ps

package slp_pkg;

    localparam int X_W        = 14;
    localparam int Y_W        = 13;
    localparam int DIM_W      = 12;
    localparam int SPEED_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_SPEED = 2'd2;

    localparam logic [DIM_W-1:0]   BOX_WIDTH_RST    = 12'd1280;
    localparam logic [DIM_W-1:0]   BOX_HEIGHT_RST   = 12'd720;
    localparam logic [SPEED_W-1:0] SCROLL_SPEED_RST = 8'd4;

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic [Y_W-1:0]        y;
        logic [DIM_W-1:0]      w;
        logic [DIM_W-1:0]      h;
    } t_entry;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
    } t_dp_status;

endpackage

@@ rtl/scrolling_overlay_lane_placer.sv @@
// A tick walks every live entry once; an add walks the table and restarts the walk from entry 0
// after each collision. A collision that pushes the rectangle past the box bottom ends the
// search at once, and an add to a full table skips the walk. One entry is examined per cycle,
// except just after a restart; one item is in work at a time.
// Reset (synchronous, active low) empties the table and restores the configuration defaults.
`timescale 1ns / 1ps

// Top level of the scrolling overlay lane placer.
//
// The block keeps an ordered table of scrolling rectangles in a RAM. An add
// transaction places a new rectangle at the right edge of the box, searching
// downward: the table is walked in insertion order and, whenever the
// candidate overlaps an entry, the candidate drops to just below that entry
// and the walk restarts from the oldest entry. The search gives up once the
// candidate would pass the bottom of the box, and the rectangle is appended
// either way, unless the table is already full, in which case the add is
// dropped and reported as not stored.
//
// A tick transaction moves every entry left by the scroll speed and compacts
// the table in place, discarding entries whose right edge has reached zero.
// Compaction writes never overtake the read pointer, so one RAM with one
// read and one write port suffices.
//
// The controller sequences each transaction; the datapath holds the table,
// the configuration and the arithmetic. The result sits in an output
// register, so a new input transaction is accepted while the previous result
// still waits to be taken. The configuration channel is always ready and
// should only be written while the block is idle.
module scrolling_overlay_lane_placer #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // Input transactions
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_operation,
    input  logic [slp_pkg::DIM_W-1:0]            i_item_width,
    input  logic [slp_pkg::DIM_W-1:0]            i_item_height,

    // Result transactions
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [slp_pkg::Y_W-1:0]              o_placed_y,
    output logic                                 o_stored,
    output logic                                 o_below_box,
    output logic [$clog2(MAX_ITEMS+1)-1:0]       o_live_count,

    // Configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [slp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [slp_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import slp_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Configuration writes complete in the cycle they are offered.
    assign o_cfg_ready = 1'b1;

    slp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    slp_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_operation   (i_operation),
        .i_item_width  (i_item_width),
        .i_item_height (i_item_height),
        .o_placed_y    (o_placed_y),
        .o_stored      (o_stored),
        .o_below_box   (o_below_box),
        .o_live_count  (o_live_count)
    );

endmodule

@@ rtl/slp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module slp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/slp_ctrl.sv @@
// Controller for the lane placer: sequences start, table scan, commit and
// result hand-off. Depends on slp_pkg.
`timescale 1ns / 1ps

module slp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output slp_pkg::t_dp_cmd   o_cmd,
    input  slp_pkg::t_dp_status i_status
);
    import slp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_RESULT
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.start    = (r_state == ST_IDLE) && i_in_valid && r_in_ready;
        o_cmd.scan     = (r_state == ST_SCAN);
        o_cmd.commit   = (r_state == ST_COMMIT);
        o_cmd.load_out = (r_state == ST_RESULT) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !o_cmd.load_out) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_cmd.start) begin
                        r_state    <= ST_SCAN;
                        r_in_ready <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (i_status.scan_done) begin
                        r_state <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    r_state <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (o_cmd.load_out) begin
                        r_state     <= ST_IDLE;
                        r_in_ready  <= 1'b1;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= ST_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    // Once an item is taken, the input closes and its scan begins.
    a_start_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (!r_in_ready && r_state == ST_SCAN))
        else $error("controller accepted an item without entering the scan");

    // A loaded result is presented and the input side reopens together.
    a_load_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> (r_out_valid && r_in_ready))
        else $error("result load did not present the result and reopen input");

endmodule

@@ rtl/slp_datapath.sv @@
// Datapath for the lane placer: configuration registers, entry table RAM,
// overlap and scroll arithmetic, scan counters and result registers.
// Depends on slp_pkg and slp_ram.
`timescale 1ns / 1ps

module slp_datapath #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  slp_pkg::t_dp_cmd                     i_cmd,
    output slp_pkg::t_dp_status                  o_status,
    input  logic                                 i_cfg_valid,
    input  logic [slp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [slp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_operation,
    input  logic [slp_pkg::DIM_W-1:0]            i_item_width,
    input  logic [slp_pkg::DIM_W-1:0]            i_item_height,
    output logic [slp_pkg::Y_W-1:0]              o_placed_y,
    output logic                                 o_stored,
    output logic                                 o_below_box,
    output logic [$clog2(MAX_ITEMS+1)-1:0]       o_live_count
);
    import slp_pkg::*;

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);

    // Configuration and control state
    logic [DIM_W-1:0]   r_box_width;
    logic [DIM_W-1:0]   r_box_height;
    logic [SPEED_W-1:0] r_speed;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_ridx;
    logic [CNT_W-1:0]   r_eidx;
    logic [CNT_W-1:0]   r_kept;
    logic               r_dv;

    // Item payload
    logic               r_op;
    logic               r_stored;
    logic [DIM_W-1:0]   r_w;
    logic [DIM_W-1:0]   r_h;
    logic [Y_W:0]       r_y;

    // Result registers
    logic [Y_W-1:0]     r_placed_y;
    logic               r_out_stored;
    logic               r_below_box;
    logic [CNT_W-1:0]   r_live_count;

    t_entry             rd_entry;
    t_entry             wr_entry;
    logic               we;
    logic               re;
    logic [IDX_W-1:0]   waddr;
    logic [IDX_W-1:0]   raddr;

    logic signed [X_W:0]   e_left;
    logic signed [X_W:0]   e_right;
    logic signed [X_W:0]   n_left;
    logic signed [X_W:0]   n_right;
    logic [Y_W:0]          ey_bot;
    logic [Y_W+1:0]        ny_bot;
    logic [Y_W+1:0]        cand_bot;
    logic [Y_W+1:0]        box_h_ext;
    logic                  hit;
    logic                  too_far;
    logic signed [X_W-1:0] nx;
    logic signed [X_W:0]   nx_right;
    logic                  keep;
    logic                  restart;

    // Overlap of the candidate rectangle with the entry just read.
    assign e_left   = {rd_entry.x[X_W-1], rd_entry.x};
    assign e_right  = e_left + $signed({{(X_W+1-DIM_W){1'b0}}, rd_entry.w});
    assign n_left   = $signed({{(X_W+1-DIM_W){1'b0}}, r_box_width});
    assign n_right  = n_left + $signed({{(X_W+1-DIM_W){1'b0}}, r_w});
    assign ey_bot   = {1'b0, rd_entry.y} + {{(Y_W+1-DIM_W){1'b0}}, rd_entry.h};
    assign ny_bot   = {1'b0, r_y} + {{(Y_W+2-DIM_W){1'b0}}, r_h};
    assign cand_bot = {1'b0, ey_bot} + {{(Y_W+2-DIM_W){1'b0}}, r_h};
    assign box_h_ext = {{(Y_W+2-DIM_W){1'b0}}, r_box_height};
    assign hit      = (e_right > n_left) && (e_left < n_right) &&
                      (ey_bot > r_y) && ({2'b00, rd_entry.y} < ny_bot);
    assign too_far  = cand_bot > box_h_ext;

    // Scroll step for the entry just read.
    assign nx       = rd_entry.x - $signed({{(X_W-SPEED_W){1'b0}}, r_speed});
    assign nx_right = {nx[X_W-1], nx} + $signed({{(X_W+1-DIM_W){1'b0}}, rd_entry.w});
    assign keep     = !nx_right[X_W] && (nx_right != '0);

    assign restart  = i_cmd.scan && (r_op == OP_ADD) && r_dv && hit;

    assign re    = i_cmd.scan && (r_ridx < r_count);
    assign raddr = r_ridx[IDX_W-1:0];

    always_comb begin
        we = (i_cmd.scan && (r_op == OP_TICK) && r_dv && keep) ||
             (i_cmd.commit && (r_op == OP_ADD) && r_stored);
        if (i_cmd.commit) begin
            waddr      = r_count[IDX_W-1:0];
            wr_entry.x = $signed({{(X_W-DIM_W){1'b0}}, r_box_width});
            wr_entry.y = r_y[Y_W-1:0];
            wr_entry.w = r_w;
            wr_entry.h = r_h;
        end else begin
            waddr      = r_kept[IDX_W-1:0];
            wr_entry.x = nx;
            wr_entry.y = rd_entry.y;
            wr_entry.w = rd_entry.w;
            wr_entry.h = rd_entry.h;
        end
    end

    always_comb begin
        o_status = '0;
        o_status.scan_done = ((r_op == OP_ADD) && !r_stored) ||
                             ((r_op == OP_ADD) && r_dv && hit && too_far) ||
                             (!r_dv && (r_ridx == r_count));
    end

    slp_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_ITEMS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_entry),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_width  <= BOX_WIDTH_RST;
            r_box_height <= BOX_HEIGHT_RST;
            r_speed      <= SCROLL_SPEED_RST;
            r_count      <= '0;
            r_ridx       <= '0;
            r_eidx       <= '0;
            r_kept       <= '0;
            r_dv         <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BOX_WIDTH:    r_box_width  <= i_cfg_data;
                    CFG_BOX_HEIGHT:   r_box_height <= i_cfg_data;
                    CFG_SCROLL_SPEED: r_speed      <= i_cfg_data[SPEED_W-1:0];
                    default:          ;
                endcase
            end
            if (i_cmd.start) begin
                r_ridx <= '0;
                r_kept <= '0;
                r_dv   <= 1'b0;
            end else if (i_cmd.scan) begin
                if (restart) begin
                    r_ridx <= '0;
                    r_dv   <= 1'b0;
                end else begin
                    r_dv   <= re;
                    r_eidx <= r_ridx;
                    if (re) begin
                        r_ridx <= r_ridx + 1'b1;
                    end
                end
                if ((r_op == OP_TICK) && r_dv && keep) begin
                    r_kept <= r_kept + 1'b1;
                end
            end else if (i_cmd.commit) begin
                if (r_op == OP_TICK) begin
                    r_count <= r_kept;
                end else if (r_stored) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op     <= i_operation;
            r_w      <= i_item_width;
            r_h      <= i_item_height;
            r_y      <= '0;
            r_stored <= (i_operation == OP_ADD) && (r_count != CNT_MAX);
        end else if (restart) begin
            r_y <= ey_bot;
        end
        if (i_cmd.load_out) begin
            r_placed_y   <= r_stored ? r_y[Y_W-1:0] : '0;
            r_out_stored <= r_stored;
            r_below_box  <= r_stored && (ny_bot > box_h_ext);
            r_live_count <= r_count;
        end
    end

    assign o_placed_y   = r_placed_y;
    assign o_stored     = r_out_stored;
    assign o_below_box  = r_below_box;
    assign o_live_count = r_live_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("table count exceeds capacity");

    // Compaction must never overtake the entry being examined.
    a_kept_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && r_dv && (r_op == OP_TICK)) |-> (r_kept <= r_eidx))
        else $error("compaction write index passed the read index");

    a_ridx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (r_ridx <= r_count))
        else $error("scan read index ran past the live entries");

endmodule
